// ===== rtl/ffba_pkg.sv =====
// shared types, codes and defaults of the first-fit block allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
   localparam int MAX_BLOCKS_DEF = 32;
   localparam logic [33:0] POOL_LIMIT_DEF = 34'd1048576;
   localparam logic [22:0] OFFSET_SPACE = 23'd1048576;
   localparam logic [20:0] INIT_CAPACITY_RST = 21'd4096;
   localparam logic [20:0] EXTENSION_RST = 21'd1024;

   typedef enum logic [1:0] {
      CMD_OBTAIN = 2'd0,
      CMD_RECYCLE = 2'd1,
      CMD_RECYCLE_ALL = 2'd2,
      CMD_UNKNOWN = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_DONE = 2'd0,
      STS_REJECTED = 2'd1,
      STS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic {
      CSR_INIT_CAPACITY = 1'b0,
      CSR_EXTENSION = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_APPLY
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [19:0] new_start;
      logic [20:0] new_length;
   } cell_ctrl_type;
endpackage
`default_nettype wire

// ===== rtl/ffba_cell.sv =====
// one table entry of the allocator chain: holds a block, finds its gap, shifts
// depends on ffba_pkg
`timescale 1ns / 1ps
`default_nettype none
module ffba_cell
   import ffba_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int CW = 6
) (
   input wire logic clock,
   input wire logic [CW-1:0] count,
   input wire logic [CW-1:0] pos,
   input wire cell_ctrl_type ctrl,
   input wire logic [20:0] req_size,
   input wire logic [19:0] find_offset,
   input wire logic [19:0] left_start,
   input wire logic [20:0] left_length,
   input wire logic [19:0] right_start,
   input wire logic [20:0] right_length,
   output logic [19:0] start,
   output logic [20:0] length,
   output logic [21:0] block_end,
   output logic fit,
   output logic match
);
   localparam logic [CW-1:0] IDX = CW'(CELL_INDEX);
   localparam logic [CW-1:0] NEXT_IDX = CW'(CELL_INDEX + 1);

   logic [19:0] start_ff, start_in;
   logic [20:0] length_ff, length_in;
   logic [21:0] gap;

   assign start = start_ff;
   assign length = length_ff;
   assign block_end = {2'b0, start_ff} + {1'b0, length_ff};
   assign gap = {2'b0, right_start} - block_end;
   assign fit = (NEXT_IDX < count) && ({2'b0, right_start} >= block_end)
      && (gap >= {1'b0, req_size});
   assign match = (IDX < count) && (start_ff == find_offset);

   always_comb begin
      start_in = start_ff;
      length_in = length_ff;
      unique case (ctrl.op)
         CELL_INSERT: begin
            if (IDX == pos) begin
               start_in = ctrl.new_start;
               length_in = ctrl.new_length;
            end else if (IDX > pos) begin
               start_in = left_start;
               length_in = left_length;
            end
         end
         CELL_REMOVE: begin
            if (IDX >= pos) begin
               start_in = right_start;
               length_in = right_length;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      length_ff <= length_in;
   end
endmodule
`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// top level of the first-fit block allocator: control sequencer and cell chain
// depends on ffba_pkg and ffba_cell
//
//  channel   ports                                     transfer when
//  request   start, busy, req_command/size/offset      start high, busy low
//  response  rsp_strobe, rsp_status/granted_offset     rsp_strobe high
//  csr       csr_write_enable, csr_index, csr_write_data  write enable high
//
// every command goes through capture, gap and match evaluation in all
// cells in parallel, then first-fit selection and the shift of the chain
// the response is registered and shows in the cycle after the shift, when busy is already low
// synchronous reset empties the table and restores capacity and extension
// the receiver cannot stall; each response is held for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter logic [33:0] POOL_LIMIT = POOL_LIMIT_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [1:0] req_command,
   input wire logic [20:0] req_request_size,
   input wire logic [19:0] req_block_offset,
   output logic rsp_strobe,
   output logic [1:0] rsp_status,
   output logic [19:0] rsp_granted_offset,
   input wire logic csr_write_enable,
   input wire logic csr_index,
   input wire logic [20:0] csr_write_data
);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_BLOCKS);

   state_type state_ff, state_in;
   logic eval_en, apply_en;

   // captured command
   logic [1:0] cmd_ff;
   logic [20:0] size_ff;
   logic [19:0] offset_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [23:0] capacity_ff, capacity_in;
   logic [20:0] extension_ff;

   logic [MAX_BLOCKS-1:0] fit_vec_ff, match_vec_ff;
   logic [MAX_BLOCKS-1:0] fit_vec, match_vec;

   logic [19:0] cell_start [MAX_BLOCKS];
   logic [20:0] cell_length [MAX_BLOCKS];
   logic [21:0] cell_end [MAX_BLOCKS];

   cell_ctrl_type ctrl;
   logic [CW-1:0] pos;

   logic rsp_strobe_ff;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [19:0] rsp_offset_ff, rsp_offset_in;

   // cell chain
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      logic [19:0] l_start, r_start;
      logic [20:0] l_length, r_length;
      if (i == 0) begin : g_first
         assign l_start = '0;
         assign l_length = '0;
      end else begin : g_mid
         assign l_start = cell_start[i-1];
         assign l_length = cell_length[i-1];
      end
      if (i == MAX_BLOCKS - 1) begin : g_last
         assign r_start = '0;
         assign r_length = '0;
      end else begin : g_next
         assign r_start = cell_start[i+1];
         assign r_length = cell_length[i+1];
      end
      ffba_cell #(.CELL_INDEX(i), .CW(CW)) u_cell (
         .clock(clock),
         .count(count_ff),
         .pos(pos),
         .ctrl(ctrl),
         .req_size(size_ff),
         .find_offset(offset_ff),
         .left_start(l_start),
         .left_length(l_length),
         .right_start(r_start),
         .right_length(r_length),
         .start(cell_start[i]),
         .length(cell_length[i]),
         .block_end(cell_end[i]),
         .fit(fit_vec[i]),
         .match(match_vec[i])
      );
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_EVAL;
         ST_EVAL: state_in = ST_APPLY;
         ST_APPLY: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy = 1'b1;
      eval_en = 1'b0;
      apply_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_EVAL: eval_en = 1'b1;
         ST_APPLY: apply_en = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   // first fitting gap, first matching block and end of the last block
   logic [MAX_BLOCKS-1:0] fit_first, match_first;
   logic [IW-1:0] fit_idx, match_idx;
   logic [21:0] gap_start, last_end;
   logic [22:0] need;
   logic [23:0] grown;

   assign fit_first = fit_vec_ff & (~fit_vec_ff + 1'b1);
   assign match_first = match_vec_ff & (~match_vec_ff + 1'b1);

   always_comb begin
      fit_idx = '0;
      match_idx = '0;
      gap_start = '0;
      last_end = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         if (fit_first[i]) begin
            fit_idx = IW'(i);
            gap_start = gap_start | cell_end[i];
         end
         if (match_first[i]) match_idx = IW'(i);
         if (CW'(i + 1) == count_ff) last_end = last_end | cell_end[i];
      end
   end

   assign need = {1'b0, last_end} + {2'b0, size_ff};
   assign grown = capacity_ff + {3'b0, size_ff} + {3'b0, extension_ff};

   always_comb begin
      ctrl.op = CELL_HOLD;
      ctrl.new_start = '0;
      ctrl.new_length = size_ff;
      pos = '0;
      count_in = count_ff;
      capacity_in = capacity_ff;
      rsp_status_in = STS_REJECTED;
      rsp_offset_in = '0;
      if (apply_en) begin
         unique case (cmd_type'(cmd_ff))
            CMD_OBTAIN: begin
               if (size_ff == '0 || count_ff >= MAX_COUNT) begin
                  rsp_status_in = STS_REJECTED;
               end else if (|fit_vec_ff) begin
                  // first gap between two blocks
                  ctrl.op = CELL_INSERT;
                  ctrl.new_start = gap_start[19:0];
                  pos = CW'(fit_idx) + 1'b1;
                  count_in = count_ff + 1'b1;
                  rsp_status_in = STS_DONE;
                  rsp_offset_in = gap_start[19:0];
               end else if ({11'b0, need} > POOL_LIMIT || need > OFFSET_SPACE) begin
                  rsp_status_in = STS_REJECTED;
               end else if ({1'b0, need} > capacity_ff
                            && {10'b0, grown} > POOL_LIMIT) begin
                  rsp_status_in = STS_REJECTED;
               end else begin
                  // append after the last block, growing the pool if needed
                  if ({1'b0, need} > capacity_ff) capacity_in = grown;
                  ctrl.op = CELL_INSERT;
                  ctrl.new_start = last_end[19:0];
                  pos = count_ff;
                  count_in = count_ff + 1'b1;
                  rsp_status_in = STS_DONE;
                  rsp_offset_in = last_end[19:0];
               end
            end
            CMD_RECYCLE: begin
               if (|match_vec_ff) begin
                  ctrl.op = CELL_REMOVE;
                  pos = CW'(match_idx);
                  count_in = count_ff - 1'b1;
                  rsp_status_in = STS_DONE;
               end else begin
                  rsp_status_in = STS_NOT_FOUND;
               end
            end
            CMD_RECYCLE_ALL: begin
               count_in = '0;
               rsp_status_in = STS_DONE;
            end
            default: rsp_status_in = STS_REJECTED;
         endcase
      end else if (csr_write_enable && csr_index == CSR_INIT_CAPACITY
                   && count_ff == '0) begin
         // capacity reload only while the table is empty
         capacity_in = {3'b0, csr_write_data};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         capacity_ff <= {3'b0, INIT_CAPACITY_RST};
         extension_ff <= EXTENSION_RST;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         capacity_ff <= capacity_in;
         if (csr_write_enable && csr_index == CSR_EXTENSION) extension_ff <= csr_write_data;
         rsp_strobe_ff <= apply_en;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         cmd_ff <= req_command;
         size_ff <= req_request_size;
         offset_ff <= req_block_offset;
      end
      if (eval_en) begin
         fit_vec_ff <= fit_vec;
         match_vec_ff <= match_vec;
      end
      if (apply_en) begin
         rsp_status_ff <= rsp_status_in;
         rsp_offset_ff <= rsp_offset_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_granted_offset = rsp_offset_ff;
endmodule
`default_nettype wire
